// ===== hw/rtl/eprka_pkg.sv =====
// Package: event codes, transaction types and field widths shared by the keepalive supervisor.
`default_nettype none
package eprka_pkg;

   localparam int unsigned REG_WIDTH   = 24;
   localparam int unsigned IDX_WIDTH   = 2;
   localparam int unsigned FUNC_WIDTH  = 3;
   localparam int unsigned REQ_DATA_W  = 8;
   localparam int unsigned RSP_DATA_W  = 8;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_TICK       = 3'd0,
      FUNC_ENTER      = 3'd1,
      FUNC_ACK        = 3'd2,
      FUNC_TX_CONFIRM = 3'd3,
      FUNC_TX_TIMEOUT = 3'd4,
      FUNC_RETRY      = 3'd5,
      FUNC_STOP       = 3'd6
   } func_type;

   typedef enum logic [IDX_WIDTH-1:0] {
      CSR_INTERVAL = 2'd0,
      CSR_RESPONSE = 2'd1,
      CSR_WATCHDOG = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic caps_known;
      logic tx_accepted;
      logic timers_active;
      func_type func;
   } item_type;

   typedef struct packed {
      logic waiting_ack;
      logic hard_reset;
      logic send_get_caps;
      logic send_keepalive;
   } result_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] interval_ticks;
      logic [REG_WIDTH-1:0] response_ticks;
      logic [REG_WIDTH-1:0] watchdog_ticks;
   } cfg_type;

endpackage
`default_nettype wire

// ===== hw/rtl/epr_keepalive_supervisor_top.sv =====
// Top level of the keepalive supervisor: stream ports, timer registers and pipeline stages.
//
// Each request transaction carries one event and yields exactly one response transaction.
// A request is registered, then decoded against the timer state, and the outcome lands in
// the response register: a response passes the request and response registers in turn.
// One transaction is taken every cycle while rsp_tready is high; all three countdowns and
// the acknowledge flag are updated in the decode cycle, which sets that rate. The user is
// to write timer reload values through the csr_ port only while no event is in flight;
// the block does not enforce it. A reload of zero expires on the next tick, like one.
`default_nettype none
module epr_keepalive_supervisor_top #(
   parameter int unsigned TIMER_BITS = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // func
   input  wire logic [eprka_pkg::FUNC_WIDTH-1:0]    req_tuser,
   // timers_active, tx_accepted, caps_known, zero pad
   input  wire logic [eprka_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // send_keepalive, send_get_caps, hard_reset, waiting_ack, zero pad
   output logic [eprka_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [eprka_pkg::IDX_WIDTH-1:0]     csr_index,
   input  wire logic [eprka_pkg::REG_WIDTH-1:0]     csr_wdata
);
   import eprka_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_result_ff;
   result_type core_result;
   logic       out_ready;
   logic       advance;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_ticks <= REG_WIDTH'(375000);
         cfg_ff.response_ticks <= REG_WIDTH'(30000);
         cfg_ff.watchdog_ticks <= REG_WIDTH'(875000);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INTERVAL: cfg_ff.interval_ticks <= csr_wdata;
            CSR_RESPONSE: cfg_ff.response_ticks <= csr_wdata;
            CSR_WATCHDOG: cfg_ff.watchdog_ticks <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.func          <= func_type'(req_tuser);
         in_item_ff.timers_active <= req_tdata[0];
         in_item_ff.tx_accepted   <= req_tdata[1];
         in_item_ff.caps_known    <= req_tdata[2];
      end
   end

   eprka_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (in_item_ff),
      .cfg        (cfg_ff),
      .result     (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-4){1'b0}}, out_result_ff};

endmodule
`default_nettype wire

// ===== hw/rtl/eprka_core.sv =====
// Countdown timers, acknowledge flag and event decode of the keepalive supervisor.
`default_nettype none
module eprka_core #(
   parameter int unsigned TIMER_BITS = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   input  wire eprka_pkg::item_type  item,
   input  wire eprka_pkg::cfg_type   cfg,
   output eprka_pkg::result_type     result
);
   import eprka_pkg::*;

   logic [TIMER_BITS-1:0] interval_left_ff, interval_left_in;
   logic [TIMER_BITS-1:0] response_left_ff, response_left_in;
   logic [TIMER_BITS-1:0] watchdog_left_ff, watchdog_left_in;
   logic                  interval_armed_ff, interval_armed_in;
   logic                  response_armed_ff, response_armed_in;
   logic                  watchdog_armed_ff, watchdog_armed_in;
   logic                  ack_pending_ff, ack_pending_in;

   logic [TIMER_BITS-1:0] interval_load, response_load, watchdog_load;
   logic                  wd_expire, rs_expire, iv_expire;
   logic                  ka, gc, hr;

   assign interval_load = TIMER_BITS'(cfg.interval_ticks);
   assign response_load = TIMER_BITS'(cfg.response_ticks);
   assign watchdog_load = TIMER_BITS'(cfg.watchdog_ticks);

   always_comb begin
      interval_left_in  = interval_left_ff;
      response_left_in  = response_left_ff;
      watchdog_left_in  = watchdog_left_ff;
      interval_armed_in = interval_armed_ff;
      response_armed_in = response_armed_ff;
      watchdog_armed_in = watchdog_armed_ff;
      ack_pending_in    = ack_pending_ff;
      wd_expire         = 1'b0;
      rs_expire         = 1'b0;
      iv_expire         = 1'b0;
      ka                = 1'b0;
      gc                = 1'b0;
      hr                = 1'b0;
      unique case (item.func)
         FUNC_TICK: begin
            if (watchdog_armed_ff) begin
               if (watchdog_left_ff[TIMER_BITS-1:1] != '0) begin
                  watchdog_left_in = watchdog_left_ff - TIMER_BITS'(1);
               end else begin
                  watchdog_left_in  = '0;
                  watchdog_armed_in = 1'b0;
                  wd_expire         = 1'b1;
               end
            end
            if (response_armed_ff) begin
               if (response_left_ff[TIMER_BITS-1:1] != '0) begin
                  response_left_in = response_left_ff - TIMER_BITS'(1);
               end else begin
                  response_left_in  = '0;
                  response_armed_in = 1'b0;
                  rs_expire         = 1'b1;
               end
            end
            if (interval_armed_ff) begin
               if (interval_left_ff[TIMER_BITS-1:1] != '0) begin
                  interval_left_in = interval_left_ff - TIMER_BITS'(1);
               end else begin
                  interval_left_in  = '0;
                  interval_armed_in = 1'b0;
                  iv_expire         = 1'b1;
               end
            end
            if (wd_expire && item.timers_active) begin
               hr = 1'b1;
            end
            if (rs_expire && item.timers_active && ack_pending_ff) begin
               ack_pending_in = 1'b0;
               hr             = 1'b1;
            end
            if (iv_expire && item.timers_active) begin
               ka = 1'b1;
               if (item.tx_accepted) begin
                  ack_pending_in    = 1'b1;
                  response_left_in  = response_load;
                  response_armed_in = 1'b1;
               end
            end
         end
         FUNC_ENTER, FUNC_RETRY: begin
            if (item.func == FUNC_RETRY && item.caps_known) begin
               if (item.timers_active) begin
                  ka = 1'b1;
                  if (item.tx_accepted) begin
                     ack_pending_in    = 1'b1;
                     response_left_in  = response_load;
                     response_armed_in = 1'b1;
                  end
               end
            end else begin
               gc = !item.caps_known;
               if (item.caps_known || item.tx_accepted) begin
                  interval_left_in  = interval_load;
                  interval_armed_in = 1'b1;
                  watchdog_left_in  = watchdog_load;
                  watchdog_armed_in = 1'b1;
               end
            end
         end
         FUNC_ACK: begin
            if (ack_pending_ff) begin
               ack_pending_in    = 1'b0;
               response_armed_in = 1'b0;
               response_left_in  = '0;
               interval_left_in  = interval_load;
               interval_armed_in = 1'b1;
            end
            watchdog_left_in  = watchdog_load;
            watchdog_armed_in = 1'b1;
         end
         FUNC_TX_CONFIRM: begin
            if (item.timers_active && !ack_pending_ff) begin
               interval_left_in  = interval_load;
               interval_armed_in = 1'b1;
            end
         end
         FUNC_TX_TIMEOUT: begin
            if (ack_pending_ff) begin
               ack_pending_in    = 1'b0;
               response_armed_in = 1'b0;
               response_left_in  = '0;
               hr                = 1'b1;
            end
         end
         FUNC_STOP: begin
            interval_armed_in = 1'b0;
            response_armed_in = 1'b0;
            watchdog_armed_in = 1'b0;
            interval_left_in  = '0;
            response_left_in  = '0;
            watchdog_left_in  = '0;
            ack_pending_in    = 1'b0;
         end
         default: begin
         end
      endcase
      result.send_keepalive = ka;
      result.send_get_caps  = gc;
      result.hard_reset     = hr;
      result.waiting_ack    = ack_pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_left_ff  <= '0;
         response_left_ff  <= '0;
         watchdog_left_ff  <= '0;
         interval_armed_ff <= 1'b0;
         response_armed_ff <= 1'b0;
         watchdog_armed_ff <= 1'b0;
         ack_pending_ff    <= 1'b0;
      end else if (item_valid) begin
         interval_left_ff  <= interval_left_in;
         response_left_ff  <= response_left_in;
         watchdog_left_ff  <= watchdog_left_in;
         interval_armed_ff <= interval_armed_in;
         response_armed_ff <= response_armed_in;
         watchdog_armed_ff <= watchdog_armed_in;
         ack_pending_ff    <= ack_pending_in;
      end
   end

endmodule
`default_nettype wire

// ===== tb/tb_epr_keepalive_supervisor_top.sv =====
// Self-checking testbench for the keepalive supervisor: predicts every response and checks it.
`timescale 1ns / 1ps
`default_nettype none
module tb_epr_keepalive_supervisor_top;
   import eprka_pkg::*;

   localparam int unsigned TIMER_BITS = 24;
   localparam logic [FUNC_WIDTH-1:0] FUNC_UNUSED = 3'd7;
   localparam int PHASE_COUNT = 17;
   localparam int PHASE_ITEMS = 100;
   localparam int PRESSURE_ITEMS = 50;
   localparam int PRESSURE_HOLD = 80;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [FUNC_WIDTH-1:0] req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we;
   logic [IDX_WIDTH-1:0] csr_index;
   logic [REG_WIDTH-1:0] csr_wdata;

   logic [REG_WIDTH-1:0] timer_reload [3] = '{24'd375000, 24'd30000, 24'd875000};
   logic [TIMER_BITS-1:0] timer_left [3] = '{'0, '0, '0};
   bit timer_armed [3] = '{1'b0, 1'b0, 1'b0};
   bit ack_wait = 1'b0;

   result_type expected_flags [$];
   string flag_names [4] = '{"send_keepalive", "send_get_caps", "hard_reset", "waiting_ack"};
   int mismatch_count = 0;
   int cycle_count = 0;
   int rsp_hold_cycles = 0;
   bit steady_flow = 1'b0;

   epr_keepalive_supervisor_top #(
      .TIMER_BITS(TIMER_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void arm_timer(csr_index_type t);
      timer_left[t] = TIMER_BITS'(timer_reload[t]);
      timer_armed[t] = 1'b1;
   endfunction

   function automatic void disarm_timer(csr_index_type t);
      timer_left[t] = '0;
      timer_armed[t] = 1'b0;
   endfunction

   function automatic bit tick_timer(csr_index_type t);
      if (!timer_armed[t]) return 1'b0;
      if (timer_left[t] > 1) begin
         timer_left[t] = timer_left[t] - 1'b1;
         return 1'b0;
      end
      disarm_timer(t);
      return 1'b1;
   endfunction

   function automatic bit keepalive_request(bit active, bit accepted);
      if (!active) return 1'b0;
      if (accepted) begin
         ack_wait = 1'b1;
         arm_timer(CSR_RESPONSE);
      end
      return 1'b1;
   endfunction

   function automatic bit enter_mode(bit accepted, bit caps);
      if (!caps && !accepted) return 1'b1;
      arm_timer(CSR_INTERVAL);
      arm_timer(CSR_WATCHDOG);
      return !caps;
   endfunction

   function automatic result_type supervise(logic [FUNC_WIDTH-1:0] code, bit active,
                                            bit accepted, bit caps);
      result_type r;
      bit wd_out;
      bit rs_out;
      bit iv_out;
      r = '0;
      case (code)
         FUNC_TICK: begin
            wd_out = tick_timer(CSR_WATCHDOG);
            rs_out = tick_timer(CSR_RESPONSE);
            iv_out = tick_timer(CSR_INTERVAL);
            if (wd_out && active) r.hard_reset = 1'b1;
            if (rs_out && active && ack_wait) begin
               ack_wait = 1'b0;
               r.hard_reset = 1'b1;
            end
            if (iv_out) r.send_keepalive = keepalive_request(active, accepted);
         end
         FUNC_ENTER: r.send_get_caps = enter_mode(accepted, caps);
         FUNC_ACK: begin
            if (ack_wait) begin
               ack_wait = 1'b0;
               disarm_timer(CSR_RESPONSE);
               arm_timer(CSR_INTERVAL);
            end
            arm_timer(CSR_WATCHDOG);
         end
         FUNC_TX_CONFIRM: if (active && !ack_wait) arm_timer(CSR_INTERVAL);
         FUNC_TX_TIMEOUT: if (ack_wait) begin
            ack_wait = 1'b0;
            disarm_timer(CSR_RESPONSE);
            r.hard_reset = 1'b1;
         end
         FUNC_RETRY: begin
            if (!caps) r.send_get_caps = enter_mode(accepted, caps);
            else r.send_keepalive = keepalive_request(active, accepted);
         end
         FUNC_STOP: begin
            ack_wait = 1'b0;
            for (int t = 0; t < 3; t++) disarm_timer(csr_index_type'(t));
         end
         default: ;
      endcase
      r.waiting_ack = ack_wait;
      return r;
   endfunction

   function automatic logic [REG_WIDTH-1:0] pick_reload();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return REG_WIDTH'(1);
         2: return '1;
         3: return REG_WIDTH'($urandom);
         default: return REG_WIDTH'($urandom_range(2, 12));
      endcase
   endfunction

   task automatic send_event(logic [FUNC_WIDTH-1:0] code, bit active, bit accepted, bit caps);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= code;
      req_tdata <= {{(REQ_DATA_W-3){1'b0}}, caps, accepted, active};
      do @(posedge clock); while (!req_tready);
      expected_flags.push_back(supervise(code, active, accepted, caps));
      @(negedge clock);
   endtask

   task automatic send_random_event();
      int unsigned roll;
      logic [FUNC_WIDTH-1:0] code;
      roll = $urandom_range(0, 99);
      if (roll < 55) code = FUNC_TICK;
      else if (roll < 62) code = FUNC_ENTER;
      else if (roll < 73) code = FUNC_ACK;
      else if (roll < 83) code = FUNC_TX_CONFIRM;
      else if (roll < 88) code = FUNC_TX_TIMEOUT;
      else if (roll < 95) code = FUNC_RETRY;
      else if (roll < 98) code = FUNC_STOP;
      else code = FUNC_UNUSED;
      send_event(code, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 80,
                 $urandom_range(0, 99) < 70);
   endtask

   // hold off until the block has drained, then write all three reload values
   task automatic load_timers(logic [REG_WIDTH-1:0] interval_val,
                              logic [REG_WIDTH-1:0] response_val,
                              logic [REG_WIDTH-1:0] watchdog_val);
      req_tvalid <= 1'b0;
      while (expected_flags.size() != 0) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_INTERVAL;
      csr_wdata <= interval_val;
      @(negedge clock);
      csr_index <= CSR_RESPONSE;
      csr_wdata <= response_val;
      @(negedge clock);
      csr_index <= CSR_WATCHDOG;
      csr_wdata <= watchdog_val;
      @(negedge clock);
      csr_we <= 1'b0;
      timer_reload[CSR_INTERVAL] = interval_val;
      timer_reload[CSR_RESPONSE] = response_val;
      timer_reload[CSR_WATCHDOG] = watchdog_val;
   endtask

   task automatic test_event_walk();
      send_event(FUNC_UNUSED, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_TICK, 1'b1, 1'b1, 1'b1);
      load_timers(24'd2, 24'd1, 24'd3);
      send_event(FUNC_ENTER, 1'b1, 1'b0, 1'b0);
      send_event(FUNC_ENTER, 1'b1, 1'b1, 1'b0);
      send_event(FUNC_TICK, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_TICK, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_TX_CONFIRM, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_TICK, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_ENTER, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_TICK, 1'b0, 1'b1, 1'b1);
      send_event(FUNC_TICK, 1'b0, 1'b1, 1'b1);
      send_event(FUNC_TICK, 1'b0, 1'b1, 1'b1);
      send_event(FUNC_RETRY, 1'b1, 1'b0, 1'b1);
      send_event(FUNC_RETRY, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_ACK, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_RETRY, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_TX_TIMEOUT, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_TX_TIMEOUT, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_RETRY, 1'b1, 1'b1, 1'b0);
      send_event(FUNC_TX_CONFIRM, 1'b1, 1'b0, 1'b0);
      send_event(FUNC_TX_CONFIRM, 1'b0, 1'b0, 1'b0);
      send_event(FUNC_RETRY, 1'b0, 1'b1, 1'b1);
      send_event(FUNC_STOP, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_TICK, 1'b1, 1'b1, 1'b1);
      send_event(FUNC_ACK, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_timer_settings();
      logic [REG_WIDTH-1:0] reload [3];
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         for (int t = 0; t < 3; t++) begin
            if (phase == 0) reload[t] = REG_WIDTH'(1);
            else if (phase == 1) reload[t] = '1;
            else if (phase == 2) reload[t] = '0;
            else reload[t] = pick_reload();
         end
         load_timers(reload[0], reload[1], reload[2]);
         steady_flow = (phase % 4 == 3);
         send_event(FUNC_ENTER, 1'b1, 1'b1, 1'($urandom_range(0, 1)));
         repeat (PHASE_ITEMS) send_random_event();
         steady_flow = 1'b0;
      end
   endtask

   task automatic test_response_backpressure();
      load_timers(24'd3, 24'd2, 24'd6);
      steady_flow = 1'b1;
      rsp_hold_cycles = PRESSURE_HOLD;
      send_event(FUNC_ENTER, 1'b1, 1'b1, 1'b1);
      repeat (PRESSURE_ITEMS) send_random_event();
      steady_flow = 1'b0;
   endtask

   initial begin
      int stall;
      result_type want;
      logic [3:0] want_bits;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (expected_flags.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_flags.pop_front();
            want_bits = want;
            for (int b = 0; b < 4; b++) begin
               if (rsp_tdata[b] !== want_bits[b]) begin
                  $display("%0t: %s expected %0b actual %0b", $time, flag_names[b],
                           want_bits[b], rsp_tdata[b]);
                  mismatch_count++;
               end
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = CSR_INTERVAL;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_event_walk();
      test_timer_settings();
      test_response_backpressure();
      req_tvalid <= 1'b0;
      while (expected_flags.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire
